[sv/hss_pkg.sv]
package hss_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned STATUS_W   = 16;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned METHOD_W   = 8;
    localparam int unsigned OUTCOME_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [TICKS_W-1:0] PREPARE_TICKS_RST = 16'd1000;
    localparam logic [TICKS_W-1:0] FINISH_TICKS_RST  = 16'd10000;

    localparam int unsigned SW_REACHED_BIT  = 10;
    localparam int unsigned SW_ATTAINED_BIT = 12;
    localparam int unsigned SW_ERROR_BIT    = 13;

    localparam int unsigned ST_REACHED  = 0;
    localparam int unsigned ST_ATTAINED = 1;
    localparam int unsigned ST_ERROR    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOMING_METHOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREPARE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_TICKS  = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_NONE             = 4'd0;
    localparam logic [OUTCOME_W-1:0] OUT_SUCCESS          = 4'd1;
    localparam logic [OUTCOME_W-1:0] OUT_STANDSTILL_TMO   = 4'd2;
    localparam logic [OUTCOME_W-1:0] OUT_ERR_BEFORE_START = 4'd3;
    localparam logic [OUTCOME_W-1:0] OUT_START_TMO        = 4'd4;
    localparam logic [OUTCOME_W-1:0] OUT_ERR_AT_START     = 4'd5;
    localparam logic [OUTCOME_W-1:0] OUT_ATTAINED_TMO     = 4'd6;
    localparam logic [OUTCOME_W-1:0] OUT_ERR_IN_PROCESS   = 4'd7;
    localparam logic [OUTCOME_W-1:0] OUT_STOP_TMO         = 4'd8;
    localparam logic [OUTCOME_W-1:0] OUT_ERR_IN_STOP      = 4'd9;
    localparam logic [OUTCOME_W-1:0] OUT_INCONSISTENT     = 4'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_BEGIN  = 2'd2,
        KIND_MODE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_STANDSTILL = 3'd1,
        PH_START      = 3'd2,
        PH_ATTAINED   = 3'd3,
        PH_STOP       = 3'd4
    } phase_t;

    typedef struct packed {
        logic [2:0]           status;
        logic                 start_flag;
        phase_t               phase;
        logic [TICKS_W-1:0]   deadline;
        logic [OUTCOME_W-1:0] last_outcome;
    } hss_state_t;

    typedef struct packed {
        logic signed [METHOD_W-1:0] homing_method;
        logic [TICKS_W-1:0]         prepare_ticks;
        logic [TICKS_W-1:0]         finish_ticks;
    } hss_cfg_t;

    typedef struct packed {
        hss_state_t st;
        logic       ended;
    } hss_step_t;

endpackage

[sv/hss_cfg.sv]
module hss_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
    output hss_pkg::hss_cfg_t              cfg
);
    import hss_pkg::*;

    hss_cfg_t cfg_reg;
    hss_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HOMING_METHOD: cfg_next.homing_method = cfg_data[METHOD_W-1:0];
                CFG_PREPARE_TICKS: cfg_next.prepare_ticks = cfg_data[TICKS_W-1:0];
                CFG_FINISH_TICKS:  cfg_next.finish_ticks  = cfg_data[TICKS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.homing_method <= '0;
            cfg_reg.prepare_ticks <= PREPARE_TICKS_RST;
            cfg_reg.finish_ticks  <= FINISH_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/hss_step.sv]
module hss_step (
    input  hss_pkg::hss_state_t          st,
    input  hss_pkg::hss_cfg_t            cfg,
    input  logic [hss_pkg::KIND_W-1:0]   kind,
    input  logic [hss_pkg::STATUS_W-1:0] status_word,
    output hss_pkg::hss_state_t          st_next,
    output logic                         ended
);
    import hss_pkg::*;

    function automatic hss_step_t run_phases(input hss_state_t st_in,
                                             input logic [TICKS_W-1:0] fin_ticks);
        hss_step_t  r;
        logic       halt;
        logic [2:0] s;
        r.st    = st_in;
        r.ended = 1'b0;
        halt    = 1'b0;
        s       = st_in.status;
        for (int i = 0; i < 4; i++) begin
            if (!halt) begin
                unique case (r.st.phase)
                    PH_STANDSTILL: begin
                        if (!s[ST_ERROR] && !s[ST_REACHED]) begin
                            halt = 1'b1;
                        end else if (s[ST_ERROR]) begin
                            r.st.last_outcome = OUT_ERR_BEFORE_START;
                            r.st.phase = PH_IDLE;
                            r.ended = 1'b1;
                            halt = 1'b1;
                        end else begin
                            r.st.start_flag = 1'b1;
                            r.st.phase = PH_START;
                        end
                    end
                    PH_START: begin
                        if (s == 3'b001) begin
                            halt = 1'b1;
                        end else if (s[ST_ERROR]) begin
                            r.st.last_outcome = OUT_ERR_AT_START;
                            r.st.phase = PH_IDLE;
                            r.ended = 1'b1;
                            halt = 1'b1;
                        end else begin
                            r.st.deadline = fin_ticks;
                            r.st.phase = PH_ATTAINED;
                        end
                    end
                    PH_ATTAINED: begin
                        if (!s[ST_ERROR] && !s[ST_ATTAINED]) begin
                            halt = 1'b1;
                        end else if (s[ST_ERROR]) begin
                            r.st.last_outcome = OUT_ERR_IN_PROCESS;
                            r.st.phase = PH_IDLE;
                            r.ended = 1'b1;
                            halt = 1'b1;
                        end else begin
                            r.st.phase = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        halt = 1'b1;
                        if (s[ST_ERROR]) begin
                            r.st.last_outcome = OUT_ERR_IN_STOP;
                            r.st.phase = PH_IDLE;
                            r.ended = 1'b1;
                        end else if (s[ST_REACHED]) begin
                            if (s[ST_ATTAINED]) begin
                                r.st.start_flag = 1'b0;
                                r.st.last_outcome = OUT_SUCCESS;
                            end else begin
                                r.st.last_outcome = OUT_INCONSISTENT;
                            end
                            r.st.phase = PH_IDLE;
                            r.ended = 1'b1;
                        end
                    end
                    default: begin
                        r.st.phase = PH_IDLE;
                        halt = 1'b1;
                    end
                endcase
            end
        end
        return r;
    endfunction

    hss_state_t pre;
    hss_step_t  res;
    logic       run_en;
    logic       tick_end;

    always_comb begin
        pre      = st;
        run_en   = 1'b0;
        tick_end = 1'b0;
        unique case (kind_t'(kind))
            KIND_STATUS: begin
                pre.status = {status_word[SW_ERROR_BIT], status_word[SW_ATTAINED_BIT],
                              status_word[SW_REACHED_BIT]};
                run_en = 1'b1;
            end
            KIND_TICK: begin
                if (st.phase != PH_IDLE) begin
                    if (st.deadline <= TICKS_W'(1)) begin
                        unique case (st.phase)
                            PH_START:    pre.last_outcome = OUT_START_TMO;
                            PH_ATTAINED: pre.last_outcome = OUT_ATTAINED_TMO;
                            PH_STOP:     pre.last_outcome = OUT_STOP_TMO;
                            default:     pre.last_outcome = OUT_STANDSTILL_TMO;
                        endcase
                        pre.deadline = '0;
                        pre.phase    = PH_IDLE;
                        tick_end     = 1'b1;
                    end else begin
                        pre.deadline = st.deadline - TICKS_W'(1);
                    end
                end
            end
            KIND_BEGIN: begin
                if (st.phase == PH_IDLE) begin
                    if (cfg.homing_method == '0) begin
                        pre.last_outcome = OUT_SUCCESS;
                        tick_end = 1'b1;
                    end else begin
                        pre.last_outcome = OUT_NONE;
                        pre.deadline     = cfg.prepare_ticks;
                        pre.phase        = PH_STANDSTILL;
                        run_en           = 1'b1;
                    end
                end
            end
            KIND_MODE: begin
                pre.start_flag = 1'b0;
                pre.status     = '0;
                run_en         = 1'b1;
            end
            default: pre = st;
        endcase
    end

    assign res     = run_phases(pre, cfg.finish_ticks);
    assign st_next = run_en ? res.st : pre;
    assign ended   = run_en ? res.ended : tick_end;

endmodule

[sv/homing_sequence_supervisor.sv]
// Homing sequence supervisor.
// Input stream: one request per item, s_tuser carries the kind (status word
// update, time tick, begin homing, mode entry reset), s_tdata the drive
// status word. Each request yields exactly one result on the m_ stream:
// start-homing control bit, busy, done and the outcome code of the latest
// sequence. Configuration (homing method, prepare and finish tick limits)
// is written through the cfg_ channel, which is always ready, and must only
// be written while no request is in flight.
// An accepted request passes the input register, then the result register
// that the phase logic loads together with the state and that drives m_tvalid.
// Throughput: one request per cycle while the receiver does not stall; the
// phase evaluation of a request is a single pass of combinational logic
// between those two registers.
// When the receiver stalls, the result register holds and the input
// register takes one more request, then s_tready drops.
// Reset (aresetn low, synchronous) empties both registers, returns the
// sequence to idle with cleared status and outcome, and loads the default
// configuration.
module homing_sequence_supervisor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hss_pkg::STATUS_W-1:0]    s_tdata,  // [15:0] status_word
    input  logic [hss_pkg::KIND_W-1:0]      s_tuser,  // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] start_homing_bit, [1] busy_res, [2] done_res, [6:3] outcome, [7] zero
    output logic [hss_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hss_pkg::*;

    hss_cfg_t            cfg;
    logic                in_valid_reg;
    logic [KIND_W-1:0]   in_kind_reg;
    logic [STATUS_W-1:0] in_status_reg;
    hss_state_t          st_reg;
    hss_state_t          st_next;
    logic                ended;
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                advance;

    assign cfg_ready = 1'b1;

    hss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hss_step u_step (
        .st          (st_reg),
        .cfg         (cfg),
        .kind        (in_kind_reg),
        .status_word (in_status_reg),
        .st_next     (st_next),
        .ended       (ended)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign out_data_next = {1'b0, st_next.last_outcome, ended,
                            (st_next.phase != PH_IDLE), st_next.start_flag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg   <= s_tuser;
            in_status_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.status       <= '0;
            st_reg.start_flag   <= 1'b0;
            st_reg.phase        <= PH_IDLE;
            st_reg.deadline     <= '0;
            st_reg.last_outcome <= OUT_NONE;
            out_valid_reg       <= 1'b0;
        end else begin
            if (advance) begin
                st_reg <= st_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[1])
        else $error("sequence ended but still busy");

    a_done_has_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[6:3] != OUT_NONE))
        else $error("sequence ended without an outcome");

    a_busy_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1] == (st_reg.phase != PH_IDLE)))
        else $error("held result disagrees with sequence state");

    a_flag_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == st_reg.start_flag))
        else $error("held start bit disagrees with state");

endmodule

[verif/homing_sequence_supervisor_test.sv]
module homing_sequence_supervisor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 60;

    typedef struct {
        kind_t kind;
        logic [STATUS_W-1:0] sw;
    } homing_req_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic done;
        logic busy;
        logic start;
    } homing_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [STATUS_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    homing_req_t req_queue[$];
    homing_res_t due_results[$];
    hss_state_t seq_state;
    hss_cfg_t seq_cfg;
    homing_req_t next_req;
    homing_res_t want;
    int n_queued;
    int n_errors = 0;
    int n_results = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int ready_pct = 100;
    int stall_phase = 0;
    int unsigned cycle_count = 0;

    homing_sequence_supervisor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic end_run(logic [OUTCOME_W-1:0] code);
        seq_state.last_outcome = code;
        seq_state.phase = PH_IDLE;
        return 1'b1;
    endfunction

    function automatic logic advance_phases();
        logic [2:0] s;
        logic fin;
        bit again;
        s = seq_state.status;
        fin = 1'b0;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (seq_state.phase)
                PH_STANDSTILL: begin
                    if (s[ST_ERROR]) begin
                        fin = end_run(OUT_ERR_BEFORE_START);
                    end else if (s[ST_REACHED]) begin
                        seq_state.start_flag = 1'b1;
                        seq_state.phase = PH_START;
                        again = 1'b1;
                    end
                end
                PH_START: begin
                    if (s[ST_ERROR]) begin
                        fin = end_run(OUT_ERR_AT_START);
                    end else if (s[ST_ATTAINED] || !s[ST_REACHED]) begin
                        seq_state.deadline = seq_cfg.finish_ticks;
                        seq_state.phase = PH_ATTAINED;
                        again = 1'b1;
                    end
                end
                PH_ATTAINED: begin
                    if (s[ST_ERROR]) begin
                        fin = end_run(OUT_ERR_IN_PROCESS);
                    end else if (s[ST_ATTAINED]) begin
                        seq_state.phase = PH_STOP;
                        again = 1'b1;
                    end
                end
                PH_STOP: begin
                    if (s[ST_ERROR]) begin
                        fin = end_run(OUT_ERR_IN_STOP);
                    end else if (s[ST_REACHED] && s[ST_ATTAINED]) begin
                        seq_state.start_flag = 1'b0;
                        fin = end_run(OUT_SUCCESS);
                    end else if (s[ST_REACHED]) begin
                        fin = end_run(OUT_INCONSISTENT);
                    end
                end
                default: begin
                    seq_state.phase = PH_IDLE;
                end
            endcase
        end
        return fin;
    endfunction

    function automatic homing_res_t homing_step(kind_t k, logic [STATUS_W-1:0] sw);
        homing_res_t r;
        logic ended;
        ended = 1'b0;
        case (k)
            KIND_STATUS: begin
                seq_state.status[ST_REACHED] = sw[SW_REACHED_BIT];
                seq_state.status[ST_ATTAINED] = sw[SW_ATTAINED_BIT];
                seq_state.status[ST_ERROR] = sw[SW_ERROR_BIT];
                ended = advance_phases();
            end
            KIND_TICK: begin
                if (seq_state.phase != PH_IDLE) begin
                    if (seq_state.deadline <= 1) begin
                        seq_state.deadline = '0;
                        case (seq_state.phase)
                            PH_START: ended = end_run(OUT_START_TMO);
                            PH_ATTAINED: ended = end_run(OUT_ATTAINED_TMO);
                            PH_STOP: ended = end_run(OUT_STOP_TMO);
                            default: ended = end_run(OUT_STANDSTILL_TMO);
                        endcase
                    end else begin
                        seq_state.deadline = seq_state.deadline - 1'b1;
                    end
                end
            end
            KIND_BEGIN: begin
                if (seq_state.phase == PH_IDLE) begin
                    seq_state.last_outcome = OUT_NONE;
                    if (seq_cfg.homing_method == 0) begin
                        ended = end_run(OUT_SUCCESS);
                    end else begin
                        seq_state.deadline = seq_cfg.prepare_ticks;
                        seq_state.phase = PH_STANDSTILL;
                        ended = advance_phases();
                    end
                end
            end
            default: begin
                seq_state.start_flag = 1'b0;
                seq_state.status = '0;
                ended = advance_phases();
            end
        endcase
        r.start = seq_state.start_flag;
        r.busy = (seq_state.phase != PH_IDLE);
        r.done = ended;
        r.outcome = seq_state.last_outcome;
        return r;
    endfunction

    function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] got_v);
        if (got_v !== exp_v) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, got_v);
        end
    endfunction

    function automatic logic [STATUS_W-1:0] status_word(logic r, logic a, logic e);
        logic [STATUS_W-1:0] w;
        w = STATUS_W'($urandom);
        w[SW_REACHED_BIT] = r;
        w[SW_ATTAINED_BIT] = a;
        w[SW_ERROR_BIT] = e;
        return w;
    endfunction

    task automatic queue_req(kind_t k, logic [STATUS_W-1:0] sw);
        req_queue.push_back('{k, sw});
        n_queued++;
    endtask

    // well-formed homing run: standstill, begun, attained, stopped, with
    // ticks in between and an occasional error
    task automatic add_homing_run();
        int err_stage;
        logic r;
        logic a;
        if ($urandom_range(0, 3) == 0) queue_req(KIND_MODE, STATUS_W'($urandom));
        queue_req(KIND_BEGIN, STATUS_W'($urandom));
        err_stage = $urandom_range(0, 7);
        for (int stage = 0; stage < 4; stage++) begin
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 12) : $urandom_range(0, 2))
                queue_req(KIND_TICK, STATUS_W'($urandom));
            if (stage == err_stage) begin
                queue_req(KIND_STATUS, status_word(1'($urandom), 1'($urandom), 1'b1));
                return;
            end
            case (stage)
                0: begin
                    r = 1'b1;
                    a = 1'b0;
                end
                1: begin
                    r = 1'b0;
                    a = ($urandom_range(0, 3) == 0);
                end
                2: begin
                    r = 1'b0;
                    a = 1'b1;
                end
                default: begin
                    r = 1'b1;
                    a = ($urandom_range(0, 5) != 0);
                end
            endcase
            queue_req(KIND_STATUS, status_word(r, a, 1'b0));
            if ($urandom_range(0, 4) == 0) queue_req(KIND_STATUS, status_word(r, a, 1'b0));
        end
    endtask

    task automatic fill_random(int count);
        n_queued = 0;
        while (n_queued < count) begin
            if ($urandom_range(0, 99) < 15)
                queue_req(kind_t'($urandom_range(0, 3)), STATUS_W'($urandom));
            else
                add_homing_run();
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (req_queue.size() != 0 || s_tvalid || due_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_HOMING_METHOD: seq_cfg.homing_method = val[METHOD_W-1:0];
            CFG_PREPARE_TICKS: seq_cfg.prepare_ticks = val;
            CFG_FINISH_TICKS: seq_cfg.finish_ticks = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] method, logic [CFG_DATA_W-1:0] prep,
                              logic [CFG_DATA_W-1:0] fin);
        write_reg(CFG_HOMING_METHOD, method);
        write_reg(CFG_PREPARE_TICKS, prep);
        write_reg(CFG_FINISH_TICKS, fin);
        @(negedge aclk);
    endtask

    // request driver: bursts of random length, random gaps between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            seq_state = '0;
            seq_cfg = '{8'sd0, PREPARE_TICKS_RST, FINISH_TICKS_RST};
        end else begin
            if (s_tvalid && s_tready)
                due_results.push_back(homing_step(kind_t'(s_tuser), s_tdata));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    next_req = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_req.kind;
                    s_tdata <= next_req.sw;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(10, 40) : $urandom_range(0, 6);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: result %h with no request pending, expected none",
                             $time, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("start_homing_bit", 4'(want.start), 4'(m_tdata[0]));
                    check_field("busy", 4'(want.busy), 4'(m_tdata[1]));
                    check_field("done", 4'(want.done), 4'(m_tdata[2]));
                    check_field("outcome", want.outcome, m_tdata[6:3]);
                    check_field("pad bit", 4'd0, 4'(m_tdata[7]));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && n_results >= 60) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
            end else begin
                stall_phase++;
                if (stall_phase % 64 == 0) begin
                    case ($urandom_range(0, 2))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        default: ready_pct = 35;
                    endcase
                end
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results still expected", $time, due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        @(negedge aclk);

        // default config: method zero succeeds at once, tick while idle
        queue_req(KIND_TICK, 16'h0000);
        queue_req(KIND_BEGIN, 16'hFFFF);
        queue_req(KIND_STATUS, 16'hFFFF);
        queue_req(KIND_MODE, 16'h0000);
        wait_drained();

        set_config(16'hFF80, 16'd3, 16'd2);
        queue_req(KIND_BEGIN, 16'h0000);
        queue_req(KIND_BEGIN, 16'h0000);
        repeat (3) queue_req(KIND_TICK, 16'h0000);
        queue_req(KIND_STATUS, 16'hFFFF);
        queue_req(KIND_BEGIN, 16'h0000);
        queue_req(KIND_MODE, 16'hFFFF);
        queue_req(KIND_STATUS, 16'h0400);
        queue_req(KIND_BEGIN, 16'h0000);
        repeat (3) queue_req(KIND_TICK, 16'hFFFF);
        queue_req(KIND_BEGIN, 16'h0000);
        queue_req(KIND_STATUS, 16'h2400);
        queue_req(KIND_MODE, 16'h0000);
        queue_req(KIND_STATUS, 16'h0400);
        queue_req(KIND_BEGIN, 16'h0000);
        queue_req(KIND_STATUS, 16'h0000);
        queue_req(KIND_TICK, 16'h0000);
        queue_req(KIND_STATUS, 16'h1000);
        queue_req(KIND_STATUS, 16'h1400);
        queue_req(KIND_BEGIN, 16'h0000);
        wait_drained();

        set_config(CFG_DATA_W'($urandom_range(1, 255)), CFG_DATA_W'($urandom_range(2, 8)),
                   CFG_DATA_W'($urandom_range(2, 8)));
        fill_random(130);
        wait_drained();

        set_config((CFG_DATA_W'($urandom) & 16'hFF00) | 16'h007F, 16'hFFFF, 16'hFFFF);
        fill_random(120);
        wait_drained();

        set_config(16'h0000, 16'd1, 16'd1);
        fill_random(40);
        wait_drained();

        set_config(CFG_DATA_W'($urandom_range(1, 255)), 16'd0,
                   CFG_DATA_W'($urandom_range(1, 6)));
        fill_random(100);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (n_errors == 0 && due_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
